>>> rtl/ssm_pkg.sv
package ssm_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int PAT_BYTES       = 16;
	localparam int CNT_W           = 32;
	localparam int LEN_CFG_W       = 5;
	localparam int REG_W           = 64;
	localparam int ADDR_W          = 5;
	localparam int REG_IDX_W       = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PAT_LO = 2'd0,
		REG_PAT_HI = 2'd1,
		REG_PAT_LEN = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic             match_valid;
		logic [CNT_W-1:0] match_start;
		logic             text_done;
		logic [CNT_W-1:0] match_total;
		logic [CNT_W-1:0] byte_total;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

endpackage

>>> rtl/ssm_cell.sv
module ssm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  ssm_pkg::cell_ctl_t ctl,
	input  ssm_pkg::byte_t    byte_in,
	input  ssm_pkg::byte_t    expect_byte,
	input  logic              active,
	output ssm_pkg::byte_t    byte_q,
	output logic              hit
);
	import ssm_pkg::*;

	// byte_in is this cell's window entry once the current beat shifts in
	assign hit = !active || (byte_in == expect_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

>>> rtl/ssm_out_buf.sv
module ssm_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ssm_pkg::result_t push_data,
	output logic             can_push,
	output logic             out_valid,
	input  logic             out_ready,
	output ssm_pkg::result_t out_data
);
	import ssm_pkg::*;

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    drain;

	assign drain     = out_v_q && out_ready;
	assign can_push  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (drain) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_v_q && !drain) begin
				skid_v_q <= 1'b1;
			end
			out_v_q <= 1'b1;
		end else if (drain) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (drain) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_v_q && !drain) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

endmodule

>>> rtl/streaming_substring_match.sv
// channel | direction | handshake             | payload
// in      | sink      | in_valid / in_ready   | text_byte, end_of_text
// out     | source    | out_valid / out_ready | match_valid, match_start, text_done,
//         |           |                       | match_total, byte_total
// cfg     | APB slave | psel/penable/pready   | paddr, pwdata, prdata
//
// One text byte is taken every cycle while in_ready is high; the window compare
// runs in parallel across the cells, so a result is registered as its byte is taken.
// Reset clears the window, counters and pattern (length 1); no clearing pass.
// A two-entry output buffer lets a byte be taken while one result waits; in_ready
// drops only when both entries hold results.
module streaming_substring_match #(
	parameter int MAX_PATTERN = ssm_pkg::MAX_PATTERN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ssm_pkg::ADDR_W-1:0]    paddr,
	input  logic [ssm_pkg::REG_W-1:0]     pwdata,
	output logic [ssm_pkg::REG_W-1:0]     prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    text_byte,
	input  logic                          end_of_text,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          match_valid,
	output logic [ssm_pkg::CNT_W-1:0]     match_start,
	output logic                          text_done,
	output logic [ssm_pkg::CNT_W-1:0]     match_total,
	output logic [ssm_pkg::CNT_W-1:0]     byte_total
);
	import ssm_pkg::*;

	localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
	localparam int GUARD_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	// configuration
	logic [REG_W-1:0]     pat_lo_q;
	logic [REG_W-1:0]     pat_hi_q;
	logic [LEN_CFG_W-1:0] pat_len_q;
	reg_idx_t             reg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_CFG_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_PAT_LO:  pat_lo_q <= pwdata;
				REG_PAT_HI:  pat_hi_q <= pwdata;
				REG_PAT_LEN: pat_len_q <= pwdata[LEN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAT_LO:  prdata = pat_lo_q;
			REG_PAT_HI:  prdata = pat_hi_q;
			REG_PAT_LEN: prdata = {{(REG_W-LEN_CFG_W){1'b0}}, pat_len_q};
			default:     prdata = '0;
		endcase
	end

	// effective length, clamped to 1..MAX_PATTERN
	logic [LEN_CFG_W-1:0] len_eff;
	always_comb begin
		if (pat_len_q == '0) begin
			len_eff = LEN_CFG_W'(1);
		end else if (pat_len_q > LEN_CFG_W'(MAX_PATTERN)) begin
			len_eff = LEN_CFG_W'(MAX_PATTERN);
		end else begin
			len_eff = pat_len_q;
		end
	end

	byte_t pat_byte [PAT_BYTES];
	for (genvar k = 0; k < PAT_BYTES; k++) begin : g_pat
		if (k < 8) begin : g_lo
			assign pat_byte[k] = pat_lo_q[8*k +: 8];
		end else begin : g_hi
			assign pat_byte[k] = pat_hi_q[8*(k-8) +: 8];
		end
	end

	// cell row
	logic      accept;
	cell_ctl_t ctl;
	byte_t     chain [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0] cell_hit;

	assign accept    = in_valid && in_ready;
	assign ctl.shift = accept;
	assign ctl.clear = accept && end_of_text;
	assign chain[0]  = text_byte;

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic [LEN_CFG_W-1:0] sel;
		logic                 act;
		assign act = LEN_CFG_W'(i) < len_eff;
		// entry i lines up with pattern byte len-1-i
		assign sel = len_eff - LEN_CFG_W'(1) - LEN_CFG_W'(i);

		ssm_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.byte_in     (chain[i]),
			.expect_byte (pat_byte[sel[3:0]]),
			.active      (act),
			.byte_q      (chain[i+1]),
			.hit         (cell_hit[i])
		);
	end

	// per-text state
	logic [FILL_W-1:0]  fill_q;
	logic [GUARD_W-1:0] guard_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   mcnt_q;

	logic [FILL_W-1:0] fill_nx;
	logic              hit;
	logic [CNT_W-1:0]  mcnt_nx;
	logic [CNT_W-1:0]  pos_nx;
	logic              has_res;
	result_t           res;

	assign fill_nx = (fill_q == FILL_W'(MAX_PATTERN)) ? fill_q : fill_q + 1'b1;
	assign hit     = (guard_q == '0) && ({{(LEN_CFG_W > FILL_W ? LEN_CFG_W - FILL_W : 0)
		{1'b0}}, fill_nx} >= len_eff) && (&cell_hit);
	assign mcnt_nx = hit ? sat_inc(mcnt_q) : mcnt_q;
	assign pos_nx  = sat_inc(pos_q);
	assign has_res = hit || end_of_text;

	always_comb begin
		res.match_valid = hit;
		res.match_start = hit ? pos_q - (CNT_W'(len_eff) - 1'b1) : '0;
		res.text_done   = end_of_text;
		res.match_total = end_of_text ? mcnt_nx : '0;
		res.byte_total  = end_of_text ? pos_nx : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			guard_q <= '0;
			pos_q   <= '0;
			mcnt_q  <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				fill_q  <= '0;
				guard_q <= '0;
				pos_q   <= '0;
				mcnt_q  <= '0;
			end else begin
				fill_q <= fill_nx;
				pos_q  <= pos_nx;
				mcnt_q <= mcnt_nx;
				if (guard_q != '0) begin
					guard_q <= guard_q - 1'b1;
				end else if (hit) begin
					// block the rest of this match from ending another
					guard_q <= GUARD_W'(len_eff - LEN_CFG_W'(1));
				end
			end
		end
	end

	// output
	result_t out_data;
	logic    can_push;

	assign in_ready = can_push;

	ssm_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && has_res),
		.push_data (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign match_valid = out_data.match_valid;
	assign match_start = out_data.match_start;
	assign text_done   = out_data.text_done;
	assign match_total = out_data.match_total;
	assign byte_total  = out_data.byte_total;

endmodule

>>> rtl/ssm_checker.sv
module ssm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        match_valid,
	input logic [31:0] match_start,
	input logic        text_done,
	input logic [31:0] match_total,
	input logic [31:0] byte_total
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_valid || text_done)
		else $error("result beat carries neither a match nor a text end");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (match_valid || match_start == 32'd0)
			&& (text_done || (match_total == 32'd0 && byte_total == 32'd0)))
		else $error("unused result fields not zero");

	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> byte_total != 32'd0 && match_total <= byte_total)
		else $error("text totals inconsistent");

endmodule

bind streaming_substring_match ssm_checker u_ssm_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
	import ssm_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 750;
	localparam int HOLD_CYCLES  = 400;

	class match_scoreboard;
		logic [REG_W-1:0]     pat_lo;
		logic [REG_W-1:0]     pat_hi;
		logic [LEN_CFG_W-1:0] pat_len;
		byte_t                window [PAT_BYTES];
		int unsigned          fill;
		logic [3:0]           guard;
		logic [CNT_W-1:0]     position;
		logic [CNT_W-1:0]     match_cnt;
		result_t              expected_q [$];
		int unsigned          mismatches;

		function new();
			pat_lo = '0;
			pat_hi = '0;
			pat_len = LEN_CFG_W'(1);
			mismatches = 0;
			clear_text();
		endfunction

		function void clear_text();
			foreach (window[i]) window[i] = '0;
			fill = 0;
			guard = '0;
			position = '0;
			match_cnt = '0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [REG_W-1:0] value);
			case (idx)
				REG_PAT_LO: pat_lo = value;
				REG_PAT_HI: pat_hi = value;
				REG_PAT_LEN: pat_len = value[LEN_CFG_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned length_in_use();
			if (pat_len == 0) return 1;
			if (pat_len > PAT_BYTES) return PAT_BYTES;
			return pat_len;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// advance the search by one text beat and queue the result it causes
		function void note_byte(byte_t b, logic last);
			int unsigned       len;
			logic              hit;
			logic [CNT_W-1:0]  first_pos;
			logic [2*REG_W-1:0] pat;
			result_t           res;
			len = length_in_use();
			pat = {pat_hi, pat_lo};
			hit = 1'b0;
			first_pos = '0;
			for (int i = PAT_BYTES - 1; i > 0; i--)
				window[i] = window[i-1];
			window[0] = b;
			if (fill < PAT_BYTES)
				fill++;
			if (guard != 0) begin
				guard--;
			end else if (fill >= len) begin
				hit = 1'b1;
				for (int k = 0; k < len; k++)
					if (window[len-1-k] != pat[k*8 +: 8])
						hit = 1'b0;
				if (hit) begin
					first_pos = position - CNT_W'(len - 1);
					guard = 4'(len - 1);
					if (match_cnt != '1)
						match_cnt++;
				end
			end
			if (position != '1)
				position++;
			if (hit || last) begin
				res.match_valid = hit;
				res.match_start = hit ? first_pos : '0;
				res.text_done = last;
				res.match_total = last ? match_cnt : '0;
				res.byte_total = last ? position : '0;
				expected_q.insert(expected_q.size(), res);
			end
			if (last)
				clear_text();
		endfunction

		task report(string msg);
			if (mismatches < 50)
				$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result with nothing pending: %p", got));
				return;
			end
			want = expected_q.pop_front();
			if (got.match_valid !== want.match_valid)
				report($sformatf("match_valid got %0b want %0b",
					got.match_valid, want.match_valid));
			if (got.match_start !== want.match_start)
				report($sformatf("match_start got %0d want %0d",
					got.match_start, want.match_start));
			if (got.text_done !== want.text_done)
				report($sformatf("text_done got %0b want %0b",
					got.text_done, want.text_done));
			if (got.match_total !== want.match_total)
				report($sformatf("match_total got %0d want %0d",
					got.match_total, want.match_total));
			if (got.byte_total !== want.byte_total)
				report($sformatf("byte_total got %0d want %0d",
					got.byte_total, want.byte_total));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0]  pwdata;
	logic [REG_W-1:0]  prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	byte_t             text_byte;
	logic              end_of_text;
	logic              out_valid;
	logic              out_ready;
	logic              match_valid;
	logic [CNT_W-1:0]  match_start;
	logic              text_done;
	logic [CNT_W-1:0]  match_total;
	logic [CNT_W-1:0]  byte_total;

	match_scoreboard sb;
	int unsigned     burst_left;
	int unsigned     items_sent;
	int unsigned     text_left;
	int unsigned     hold_left;
	int unsigned     rx_tick;
	int unsigned     rx_mode;
	int unsigned     quiet_cycles;

	streaming_substring_match DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.match_valid(match_valid),
		.match_start(match_start),
		.text_done(text_done),
		.match_total(match_total),
		.byte_total(byte_total)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic apb_write(reg_idx_t idx, logic [REG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic send_beat(byte_t b, logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= last;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b, last);
		items_sent++;
	endtask

	// close the current text after a random number of beats
	task automatic emit_byte(byte_t b);
		logic last;
		if (text_left == 0)
			text_left = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 48);
		text_left--;
		last = (text_left == 0);
		send_beat(b, last);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.pending() != 0);
		// results with no beat still in flight
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(bit flood);
		byte_t                pat [PAT_BYTES];
		byte_t                alpha [3];
		logic [LEN_CFG_W-1:0] len_reg;
		logic [2*REG_W-1:0]   packed_pat;
		int unsigned          len;
		int unsigned          n_alpha;
		int unsigned          budget;
		int unsigned          pick;
		int unsigned          cnt;
		pick = $urandom_range(0, 9);
		if (flood)
			len_reg = LEN_CFG_W'(1);
		else if (pick == 0)
			len_reg = '0;
		else if (pick == 1)
			len_reg = LEN_CFG_W'($urandom_range(PAT_BYTES + 1, 31));
		else if (pick == 2)
			len_reg = LEN_CFG_W'(PAT_BYTES);
		else
			len_reg = LEN_CFG_W'($urandom_range(1, $urandom_range(0, 1) ? 4 : PAT_BYTES));
		len = (len_reg == 0) ? 1 : (len_reg > PAT_BYTES) ? PAT_BYTES : len_reg;
		n_alpha = flood ? 1 : $urandom_range(1, 4);
		foreach (alpha[i]) alpha[i] = byte_t'($urandom_range(0, 255));
		foreach (pat[i]) begin
			if (i < len && n_alpha < 4)
				pat[i] = alpha[$urandom_range(0, n_alpha - 1)];
			else
				pat[i] = byte_t'($urandom_range(0, 255));
			packed_pat[i*8 +: 8] = pat[i];
		end
		apb_write(REG_PAT_LO, packed_pat[REG_W-1:0]);
		apb_write(REG_PAT_HI, packed_pat[2*REG_W-1:REG_W]);
		apb_write(REG_PAT_LEN, REG_W'(len_reg));
		if (flood)
			hold_left = HOLD_CYCLES;
		budget = $urandom_range(30, 90);
		while (budget > 0) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3 || (pick <= 5 && len == 1)) begin
				for (int i = 0; i < len; i++)
					emit_byte(pat[i]);
				cnt = len;
			end else if (pick <= 5) begin
				cnt = $urandom_range(1, len - 1);
				for (int i = 0; i < cnt; i++)
					emit_byte(pat[i]);
			end else if (pick <= 8 && n_alpha < 4) begin
				cnt = $urandom_range(1, 3);
				repeat (cnt) emit_byte(alpha[$urandom_range(0, n_alpha - 1)]);
			end else begin
				cnt = $urandom_range(1, 2);
				repeat (cnt) emit_byte(byte_t'($urandom_range(0, 255)));
			end
			budget = (cnt >= budget) ? 0 : budget - cnt;
		end
		// the text may stay open, so the next length change lands mid-text
		drain();
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(result_t'{match_valid, match_start, text_done,
				match_total, byte_total});
	end

	// receiver: stall pattern changes every so often, with long holds on request
	initial begin
		out_ready = 1'b0;
		rx_tick = 0;
		rx_mode = 0;
		forever begin
			@(posedge clk);
			rx_tick++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (rx_tick % 97 == 0)
					rx_mode = $urandom_range(0, 3);
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= (rx_tick % 4 != 3);
					2: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int unsigned phase;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		text_byte = '0;
		end_of_text = 1'b0;
		hold_left = 0;
		burst_left = 0;
		items_sent = 0;
		text_left = 0;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern is a single zero byte: match on the final byte too
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h00, 1'b1);
		drain();

		// length zero behaves as one
		apb_write(REG_PAT_LO, REG_W'(8'hA5));
		apb_write(REG_PAT_LEN, '0);
		send_beat(8'hA5, 1'b0);
		send_beat(8'h5A, 1'b1);
		drain();

		// oversized length clamps to sixteen; guard blocks the overlapping run
		apb_write(REG_PAT_LO, '1);
		apb_write(REG_PAT_HI, '1);
		apb_write(REG_PAT_LEN, REG_W'(20));
		repeat (17) send_beat(8'hFF, 1'b0);
		send_beat(8'hFF, 1'b1);
		drain();

		phase = 0;
		while (items_sent < RANDOM_ITEMS + 23) begin
			random_phase(phase == 2);
			phase++;
		end
		drain();
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
